// File: rtl/flptm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flptm_pkg
// Shared types and constants of the four-level page table mapper.
// ----------------------------------------------------------------------------
package flptm_pkg;

	// field widths
	localparam int ENT_W   = 64;
	localparam int BASE_W  = 40;
	localparam int IDX_W   = 9;
	localparam int CNT_W   = 21;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	// command codes
	localparam logic [1:0] CMD_MAP_2M    = 2'd0;
	localparam logic [1:0] CMD_MAP_4K    = 2'd1;
	localparam logic [1:0] CMD_MAP_RANGE = 2'd2;
	localparam logic [1:0] CMD_READ      = 2'd3;

	// register index (paddr bit 3)
	localparam logic REG_TABLE_BASE = 1'b0;

	// status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// entry bits and masks
	localparam logic [63:0] ENT_PRESENT = 64'h001;
	localparam logic [63:0] ENT_WRITE   = 64'h002;
	localparam logic [63:0] ENT_HUGE    = 64'h080;
	localparam logic [63:0] MASK_4K     = ~64'hfff;
	localparam logic [63:0] MASK_2M     = ~64'h1fffff;
	localparam logic [63:0] PAGE_BYTES  = 64'h1000;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] limit;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] sum;
		logic        below;
	} alu_rsp_t;

endpackage

// File: rtl/flptm_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flptm_cmd_if
// Request channel of the page table mapper: valid, ready and command fields.
// ----------------------------------------------------------------------------
interface flptm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [63:0] virt_addr;
	logic [63:0] phys_addr;
	logic [11:0] flags;
	logic [31:0] range_size;
	logic [5:0]  table_page;
	logic [8:0]  entry_index;

	modport source (
		output valid, command, virt_addr, phys_addr, flags, range_size,
		       table_page, entry_index,
		input  ready
	);

	modport sink (
		input  valid, command, virt_addr, phys_addr, flags, range_size,
		       table_page, entry_index,
		output ready
	);
endinterface

// File: rtl/flptm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flptm_rsp_if
// Result channel of the page table mapper: valid, ready, status and entry.
// ----------------------------------------------------------------------------
interface flptm_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [63:0] entry_value;

	modport source (
		output valid, status, entry_value,
		input  ready
	);

	modport sink (
		input  valid, status, entry_value,
		output ready
	);
endinterface

// File: rtl/flptm_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flptm_alu
// Shared 64-bit add/subtract unit with an unsigned below-limit compare.
// ----------------------------------------------------------------------------
module flptm_alu (
	input  flptm_pkg::alu_req_t req,
	output flptm_pkg::alu_rsp_t rsp
);
	import flptm_pkg::*;

	logic [63:0] sum;

	// add or subtract, modulo 2^64
	always_comb begin
		case (req.op)
			ALU_SUB: sum = req.a - req.b;
			default: sum = req.a + req.b;
		endcase
	end

	assign rsp.sum   = sum;
	assign rsp.below = (sum < req.limit);
endmodule

// File: rtl/flptm_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flptm_table_ram
// Table pool storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module flptm_table_ram #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem [DEPTH];
	logic [63:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/four_level_page_table_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// Builds four-level x86-64 page tables in an internal pool of table pages.
// ----------------------------------------------------------------------------
// Requests arrive on cmd (valid/ready) and each one gives exactly one result
// on rsp: status (0 ok, 1 pool exhausted) and, for a read, the stored entry.
// table_base_frame is written over the APB port; it is 40 bits wide at
// address 0 and must only change while the block is idle.
// A sequencer walks the levels through one table memory with a registered
// read port and one shared add/subtract unit. Each level passes through a read
// state and a check state, plus a link write when a table is allocated. A
// range request makes one walk per 4 KiB page, with a virtual and then a
// physical address advance between pages. cmd.ready is high only in idle;
// one request is worked on at a time.
// After reset the memory is cleared one entry a cycle, all POOL_PAGES*512
// entries (32768 by default), and no request is taken meanwhile. A result
// waits in the output register while rsp stalls; the next request may be
// accepted, and its result is held back until the register is free.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper #(
	parameter int POOL_PAGES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	flptm_cmd_if.sink                        cmd,
	flptm_rsp_if.source                      rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [flptm_pkg::PADDR_W-1:0]    paddr,
	input  logic [flptm_pkg::PDATA_W-1:0]    pwdata,
	output logic [flptm_pkg::PDATA_W-1:0]    prdata,
	output logic                             pready
);
	import flptm_pkg::*;

	localparam int PW    = (POOL_PAGES > 2) ? $clog2(POOL_PAGES) : 1;
	localparam int NFW   = $clog2(POOL_PAGES + 1);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = POOL_PAGES * 512;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_LINK,
		ST_LEAF,
		ST_ADV_V,
		ST_ADV_P,
		ST_RDC,
		ST_RDW,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [BASE_W-1:0] base_q;
	logic [NFW-1:0]    nfp_q;
	logic [1:0]        cmd_q;
	logic [63:0]       va_q;
	logic [63:0]       pa_q;
	logic [11:0]       flags_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [5:0]        rpage_q;
	logic [IDX_W-1:0]  ridx_q;
	logic [1:0]        level_q;
	logic [PW-1:0]     page_q;
	logic [PW-1:0]     child_q;
	logic              fail_q;
	logic [63:0]       val_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic [63:0]       out_value_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [63:0]       mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [63:0]       mem_rdata;

	logic [IDX_W-1:0]  lvl_idx;
	logic [AW-1:0]     slot;
	logic              read_in_pool;
	logic [AW-1:0]     read_addr;
	logic              present_ok;
	logic              hit;
	logic              pool_full;
	logic [1:0]        leaf_level;
	logic [63:0]       leaf_entry;
	logic [32:0]       range_end;
	logic              cfg_we;
	logic              fin_fire;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == REG_TABLE_BASE) ? {{(PDATA_W-BASE_W){1'b0}}, base_q}
	                                              : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we && paddr[3] == REG_TABLE_BASE) begin
			base_q <= pwdata[BASE_W-1:0];
		end
	end

	// entry slot of the current level
	assign lvl_idx = va_q[12 + 9*level_q +: IDX_W];
	assign slot    = {page_q, lvl_idx};

	// direct entry read
	assign read_in_pool = (32'(rpage_q) < 32'(POOL_PAGES));
	assign read_addr    = read_in_pool ? {PW'(rpage_q), ridx_q} : '0;

	// page count of a range request, rounded up
	assign range_end = {1'b0, cmd.range_size} + 33'(cmd.virt_addr[11:0]) + 33'h0fff;

	// pointer check and leaf entry
	assign present_ok = mem_rdata[0] && !(level_q == 2'd1 && mem_rdata[7]);
	assign hit        = present_ok && alu_rsp.below;
	assign pool_full  = (nfp_q == NFW'(POOL_PAGES));
	assign leaf_level = (cmd_q == CMD_MAP_2M) ? 2'd1 : 2'd0;

	always_comb begin
		if (cmd_q == CMD_MAP_2M) begin
			leaf_entry = (pa_q & MASK_2M) | 64'(flags_q) | ENT_PRESENT | ENT_HUGE;
		end else begin
			leaf_entry = (pa_q & MASK_4K) | 64'(flags_q) | ENT_PRESENT;
		end
	end

	// shared unit operand selection
	always_comb begin
		alu_req.op    = ALU_ADD;
		alu_req.a     = {{(64-BASE_W){1'b0}}, base_q};
		alu_req.b     = 64'(child_q);
		alu_req.limit = '0;
		case (state_q)
			ST_CHK: begin
				alu_req.op    = ALU_SUB;
				alu_req.a     = {12'b0, mem_rdata[63:12]};
				alu_req.b     = {{(64-BASE_W){1'b0}}, base_q};
				alu_req.limit = 64'(nfp_q);
			end
			ST_ADV_V: begin
				alu_req.a = va_q;
				alu_req.b = PAGE_BYTES;
			end
			ST_ADV_P: begin
				alu_req.a = pa_q;
				alu_req.b = PAGE_BYTES;
			end
			default: begin
			end
		endcase
	end

	flptm_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot;
		mem_wdata = leaf_entry;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_LINK: begin
				mem_we    = 1'b1;
				mem_wdata = {alu_rsp.sum[51:0], 12'b0} | ENT_PRESENT | ENT_WRITE;
			end
			ST_LEAF: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign mem_raddr = (state_q == ST_RDC) ? read_addr : slot;

	flptm_table_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result register takes a new result once the old one has gone
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			nfp_q        <= NFW'(1);
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_OK;
			out_value_q  <= '0;
			cmd_q        <= CMD_MAP_2M;
			va_q         <= '0;
			pa_q         <= '0;
			flags_q      <= '0;
			cnt_q        <= '0;
			rpage_q      <= '0;
			ridx_q       <= '0;
			level_q      <= '0;
			page_q       <= '0;
			child_q      <= '0;
			fail_q       <= STATUS_OK;
			val_q        <= '0;
		end else begin
			if (fin_fire) begin
				out_valid_q  <= 1'b1;
				out_status_q <= fail_q;
				out_value_q  <= val_q;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.valid) begin
						cmd_q   <= cmd.command;
						va_q    <= cmd.virt_addr;
						pa_q    <= cmd.phys_addr;
						flags_q <= cmd.flags;
						rpage_q <= cmd.table_page;
						ridx_q  <= cmd.entry_index;
						cnt_q   <= range_end[32:12];
						level_q <= 2'd3;
						page_q  <= '0;
						fail_q  <= STATUS_OK;
						val_q   <= '0;
						if (cmd.command == CMD_READ) begin
							state_q <= ST_RDC;
						end else if (cmd.command == CMD_MAP_RANGE &&
						             range_end[32:12] == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (hit) begin
						page_q  <= alu_rsp.sum[PW-1:0];
						level_q <= level_q - 2'd1;
						state_q <= (level_q - 2'd1 == leaf_level) ? ST_LEAF : ST_RD;
					end else if (pool_full) begin
						fail_q  <= STATUS_FULL;
						state_q <= ST_FIN;
					end else begin
						child_q <= nfp_q[PW-1:0];
						nfp_q   <= nfp_q + NFW'(1);
						state_q <= ST_LINK;
					end
				end
				ST_LINK: begin
					page_q  <= child_q;
					level_q <= level_q - 2'd1;
					state_q <= (level_q - 2'd1 == leaf_level) ? ST_LEAF : ST_RD;
				end
				ST_LEAF: begin
					if (cmd_q == CMD_MAP_RANGE && cnt_q != CNT_W'(1)) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= ST_ADV_V;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_ADV_V: begin
					va_q    <= alu_rsp.sum;
					state_q <= ST_ADV_P;
				end
				ST_ADV_P: begin
					pa_q    <= alu_rsp.sum;
					level_q <= 2'd3;
					page_q  <= '0;
					state_q <= ST_RD;
				end
				ST_RDC: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					val_q   <= read_in_pool ? mem_rdata : '0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_value = out_value_q;

	// allocation pointer stays within the pool
	a_nfp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nfp_q >= NFW'(1)) && (32'(nfp_q) <= 32'(POOL_PAGES)))
		else $error("allocation pointer outside pool");

	// pages are only taken while checking a pointer
	a_nfp_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(nfp_q != $past(nfp_q)) |-> ($past(state_q) == ST_CHK))
		else $error("allocation outside pointer check");

	// no request taken during the clearing pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !cmd.ready)
		else $error("request accepted while clearing");

	// writes stay inside the memory
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(mem_waddr) < 32'(DEPTH)))
		else $error("table write outside memory");

	// a link always points at a freshly allocated page
	a_link_child: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINK) |-> (32'(child_q) + 32'd1 == 32'(nfp_q)))
		else $error("link does not use the newest page");
endmodule

// File: sim/tb_four_level_page_table_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_mapper
// Self-checking bench for the four-level page table mapper.
// ----------------------------------------------------------------------------
// A short stimulus table covers reset reads, field extremes, huge and small
// maps, huge-over-table and table-over-huge replacement, range wrap and
// zero length, and stale pointers after a base change. Random phases then
// map into a small set of virtual regions so walks mostly hit live tables,
// under several table base settings, until the pool runs dry. A shadow copy
// of the table pool predicts every result; results are checked in order.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_mapper;
	import flptm_pkg::*;

	localparam int TBL_PAGES = 64;
	localparam int PHASE_LEN = 105;
	localparam int HOLD_CYCLES = 300;
	localparam logic [PADDR_W-1:0] BASE_ADDR = {REG_TABLE_BASE, 3'b000};

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] virt_addr;
		logic [63:0] phys_addr;
		logic [11:0] flags;
		logic [31:0] range_size;
		logic [5:0]  table_page;
		logic [8:0]  entry_index;
	} map_req_t;

	typedef struct packed {
		logic        status;
		logic [63:0] entry_value;
	} map_rsp_t;

	typedef enum logic [1:0] {
		STEP_PREDICT,
		STEP_EXPECT_ZERO,
		STEP_SET_BASE
	} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		map_req_t   req;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	flptm_cmd_if cmd_ch ();
	flptm_rsp_if rsp_ch ();

	four_level_page_table_mapper #(
		.POOL_PAGES(TBL_PAGES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// shadow copy of the table pool
	logic [63:0] shadow_tables [0:TBL_PAGES*512-1];
	int unsigned shadow_next;
	logic [39:0] shadow_base;

	map_rsp_t due_results[$];
	stim_row_t stim_table[$];
	int fail_count;
	bit steady;
	int hold_requests;
	int holds_served;
	int stall_left;
	map_rsp_t want;
	logic [8:0] addr_l4 [2];
	logic [8:0] addr_l3 [2];
	logic [8:0] addr_l2 [3];
	logic [8:0] addr_l1 [4];

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#25_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned slot_at(input int unsigned page, input logic [63:0] va,
			input int shift);
		logic [8:0] ix;
		ix = va[shift +: 9];
		return page * 512 + 32'(ix);
	endfunction

	// follow a table pointer, or take a fresh page and link it in
	function automatic bit link_or_alloc(input int unsigned slot, input bit replace_huge,
			output int unsigned child);
		logic [63:0] ent;
		logic [63:0] off;
		ent = shadow_tables[slot];
		child = 0;
		if ((ent & ENT_PRESENT) != 0 && !(replace_huge && (ent & ENT_HUGE) != 0)) begin
			off = (ent >> 12) - {24'd0, shadow_base};
			if (off < 64'(shadow_next)) begin
				child = off[31:0];
				return 1'b1;
			end
		end
		if (shadow_next >= TBL_PAGES)
			return 1'b0;
		child = shadow_next;
		shadow_next++;
		shadow_tables[slot] = (({24'd0, shadow_base} + 64'(child)) << 12) | ENT_PRESENT
			| ENT_WRITE;
		return 1'b1;
	endfunction

	function automatic bit walk_to_directory(input logic [63:0] va, output int unsigned dir);
		int unsigned upper;
		dir = 0;
		if (!link_or_alloc(slot_at(0, va, 39), 1'b0, upper))
			return 1'b0;
		return link_or_alloc(slot_at(upper, va, 30), 1'b0, dir);
	endfunction

	function automatic logic map_huge(input logic [63:0] va, input logic [63:0] pa,
			input logic [11:0] fl);
		int unsigned dir;
		if (!walk_to_directory(va, dir))
			return STATUS_FULL;
		shadow_tables[slot_at(dir, va, 21)] = (pa & MASK_2M) | 64'(fl) | ENT_PRESENT | ENT_HUGE;
		return STATUS_OK;
	endfunction

	function automatic logic map_small(input logic [63:0] va, input logic [63:0] pa,
			input logic [11:0] fl);
		int unsigned dir;
		int unsigned tbl;
		if (!walk_to_directory(va, dir))
			return STATUS_FULL;
		if (!link_or_alloc(slot_at(dir, va, 21), 1'b1, tbl))
			return STATUS_FULL;
		shadow_tables[slot_at(tbl, va, 12)] = (pa & MASK_4K) | 64'(fl) | ENT_PRESENT;
		return STATUS_OK;
	endfunction

	// range as 4 KiB pages, addresses wrap at 2^64
	function automatic logic map_span(input logic [63:0] va, input logic [63:0] pa,
			input logic [31:0] size, input logic [11:0] fl);
		logic [63:0] vs;
		logic [63:0] ps;
		logic [63:0] total;
		logic [63:0] off;
		vs = va & MASK_4K;
		ps = pa & MASK_4K;
		total = (64'(size) + (va - vs) + 64'hfff) & MASK_4K;
		off = 0;
		while (off < total) begin
			if (map_small(vs + off, ps + off, fl) == STATUS_FULL)
				return STATUS_FULL;
			off += PAGE_BYTES;
		end
		return STATUS_OK;
	endfunction

	function automatic map_rsp_t map_or_read(input map_req_t r);
		map_rsp_t res;
		res.status = STATUS_OK;
		res.entry_value = '0;
		case (r.command)
			CMD_MAP_2M: res.status = map_huge(r.virt_addr, r.phys_addr, r.flags);
			CMD_MAP_4K: res.status = map_small(r.virt_addr, r.phys_addr, r.flags);
			CMD_MAP_RANGE: res.status = map_span(r.virt_addr, r.phys_addr, r.range_size, r.flags);
			default: begin
				if (32'(r.table_page) < TBL_PAGES)
					res.entry_value = shadow_tables[32'(r.table_page) * 512 + 32'(r.entry_index)];
			end
		endcase
		return res;
	endfunction

	function automatic map_req_t mk_req(input logic [1:0] c, input logic [63:0] va,
			input logic [63:0] pa, input logic [11:0] fl, input logic [31:0] size,
			input logic [5:0] page, input logic [8:0] idx);
		map_req_t r;
		r.command = c;
		r.virt_addr = va;
		r.phys_addr = pa;
		r.flags = fl;
		r.range_size = size;
		r.table_page = page;
		r.entry_index = idx;
		return r;
	endfunction

	function automatic stim_row_t stim_row(input step_kind_t k, input logic [1:0] c,
			input logic [63:0] va, input logic [63:0] pa, input logic [11:0] fl,
			input logic [31:0] size, input logic [5:0] page, input logic [8:0] idx);
		stim_row_t s;
		s.kind = k;
		s.req = mk_req(c, va, pa, fl, size, page, idx);
		return s;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly walks into the chosen regions, some reads, a little noise
	function automatic map_req_t random_request();
		map_req_t r;
		int pick;
		logic [63:0] va;
		va = rand64();
		va[47:39] = addr_l4[$urandom_range(0, 1)];
		va[38:30] = addr_l3[$urandom_range(0, 1)];
		va[29:21] = addr_l2[$urandom_range(0, 2)];
		if ($urandom_range(0, 1) == 0)
			va[20:12] = addr_l1[$urandom_range(0, 3)];
		r = mk_req(CMD_READ, va, rand64(), 12'($urandom_range(0, 4095)),
			32'($urandom_range(0, 24576)), 6'($urandom_range(0, shadow_next - 1)),
			9'($urandom_range(0, 511)));
		if ($urandom_range(0, 7) == 0)
			r.range_size = '0;
		if ($urandom_range(0, 3) == 0)
			r.table_page = 6'($urandom_range(0, 63));
		case ($urandom_range(0, 3))
			0: r.entry_index = va[47:39];
			1: r.entry_index = va[38:30];
			2: r.entry_index = va[29:21];
			default: r.entry_index = va[20:12];
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			r.command = CMD_MAP_4K;
		end else if (pick < 55) begin
			r.command = CMD_MAP_RANGE;
			// wide ranges only once the pool is spent, so they stop early
			if (shadow_next >= TBL_PAGES && $urandom_range(0, 3) == 0) begin
				r.range_size = $urandom;
				r.virt_addr = rand64();
			end
		end else if (pick < 65) begin
			r.command = CMD_MAP_2M;
		end else if (pick >= 92) begin
			r.command = pick[0] ? CMD_MAP_4K : CMD_MAP_2M;
			r.virt_addr = rand64();
		end
		return r;
	endfunction

	// offer one request, predict its result when it is taken
	task automatic send_request(input map_req_t r, input bit expect_zero);
		map_rsp_t res;
		while (!steady && $urandom_range(0, 99) < 25) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= r.command;
		cmd_ch.virt_addr <= r.virt_addr;
		cmd_ch.phys_addr <= r.phys_addr;
		cmd_ch.flags <= r.flags;
		cmd_ch.range_size <= r.range_size;
		cmd_ch.table_page <= r.table_page;
		cmd_ch.entry_index <= r.entry_index;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		res = map_or_read(r);
		if (expect_zero)
			res = {STATUS_OK, 64'd0};
		due_results.push_back(res);
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	// write the table base, then read it back
	task automatic program_base(input logic [39:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BASE_ADDR;
		pwdata <= 64'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		shadow_base = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== 64'(val)) begin
			$error("table_base_frame: expected %h, got %h", 64'(val), prdata);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// result side: random stalls, one long hold-off on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			stall_left = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0d entry_value %h", rsp_ch.status,
					rsp_ch.entry_value);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.entry_value !== want.entry_value) begin
					$error("entry_value: expected %h, got %h", want.entry_value,
						rsp_ch.entry_value);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int ph;
		int n;
		int guard;
		logic [39:0] phase_base [5];

		// known levels from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_MAP_2M;
		cmd_ch.virt_addr = '0;
		cmd_ch.phys_addr = '0;
		cmd_ch.flags = '0;
		cmd_ch.range_size = '0;
		cmd_ch.table_page = '0;
		cmd_ch.entry_index = '0;
		rsp_ch.ready = 1'b0;
		fail_count = 0;
		steady = 1'b0;
		hold_requests = 0;
		holds_served = 0;
		stall_left = 0;
		for (int i = 0; i < TBL_PAGES * 512; i++)
			shadow_tables[i] = '0;
		shadow_next = 1;
		shadow_base = '0;
		foreach (addr_l4[i]) addr_l4[i] = 9'($urandom_range(0, 511));
		foreach (addr_l3[i]) addr_l3[i] = 9'($urandom_range(0, 511));
		foreach (addr_l2[i]) addr_l2[i] = 9'($urandom_range(0, 511));
		foreach (addr_l1[i]) addr_l1[i] = 9'($urandom_range(0, 511));
		phase_base[0] = '0;
		phase_base[1] = 40'(rand64());
		phase_base[2] = '1;
		phase_base[3] = '0;
		phase_base[4] = 40'(rand64());

		// directed table
		// empty root after reset, and the last entry of the last page
		stim_table.push_back(stim_row(STEP_EXPECT_ZERO, CMD_READ, '0, '0, '0, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_EXPECT_ZERO, CMD_READ, '1, '1, '1, '1, 63, 511));
		// first walk builds three tables
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_4K, '0, '1, 12'hfff, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_READ, '0, '0, '0, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_READ, '0, '0, '0, '0, 3, 0));
		// huge page over a page table, then a table over the huge page
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_2M, '0, '1, '0, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_READ, '0, '0, '0, '0, 2, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_4K, 64'h1000, '0, '0, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_READ, '0, '0, '0, '0, 2, 0));
		// top of the address space
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_2M, '1, '0, 12'hfff, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_4K, '1,
			64'h1234_5678_9abc_def0, 12'h080, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_READ, '0, '0, '0, '0, 7, 511));
		// zero length aligned maps nothing, unaligned maps one page
		stim_table.push_back(stim_row(STEP_EXPECT_ZERO, CMD_MAP_RANGE, 64'h4000_0000, '0,
			'0, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_RANGE, 64'h4000_0123,
			64'h8000_0456, 12'h002, '0, 0, 0));
		// range across a 2 MiB boundary, and one that wraps past the top
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_RANGE, 64'h1f_f800, 64'h30_0000,
			12'h004, 32'h1000, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_RANGE, 64'hffff_ffff_ffff_f800,
			64'h5000, '0, 32'h1000, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_READ, '0, '0, '0, '0, 0, 511));
		// stale pointers after the base moves away and back
		stim_table.push_back(stim_row(STEP_SET_BASE, CMD_READ, '0, 64'h12_3450_0000, '0, '0,
			0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_4K, 64'h20_3000, 64'h7000, '0,
			'0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_READ, '0, '0, '0, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_SET_BASE, CMD_READ, '0, '0, '0, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_MAP_2M, 64'h40_0000, 64'h60_0000,
			'0, '0, 0, 0));
		stim_table.push_back(stim_row(STEP_PREDICT, CMD_READ, '0, '0, '0, '0, 0, 0));

		// reset, then the block clears its pool before taking requests
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			case (stim_table[i].kind)
				STEP_SET_BASE: begin
					drain_results();
					program_base(stim_table[i].req.phys_addr[39:0]);
				end
				STEP_EXPECT_ZERO: send_request(stim_table[i].req, 1'b1);
				default: send_request(stim_table[i].req, 1'b0);
			endcase
		end

		// random phases, each after programming a table base
		for (ph = 0; ph < 5; ph++) begin
			drain_results();
			program_base(phase_base[ph]);
			@(posedge clk);
			steady = (ph == 2);
			if (ph == 1)
				hold_requests++;
			@(negedge clk);
			for (n = 0; n < PHASE_LEN; n++)
				send_request(random_request(), 1'b0);
		end

		// use up what is left of the pool, then requests that must fail
		guard = 0;
		while (shadow_next < TBL_PAGES && guard < 200) begin
			send_request(mk_req(CMD_MAP_4K, rand64(), rand64(), 12'($urandom_range(0, 4095)),
				'0, '0, '0), 1'b0);
			guard++;
		end
		send_request(mk_req(CMD_MAP_RANGE, rand64(), rand64(), '0, '1, '0, '0), 1'b0);
		send_request(mk_req(CMD_MAP_2M, rand64(), rand64(), '0, '0, '0, '0), 1'b0);
		send_request(mk_req(CMD_MAP_4K, rand64(), rand64(), '1, '0, '0, '0), 1'b0);
		send_request(mk_req(CMD_READ, '0, '0, '0, '0, 0, 0), 1'b0);

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/flptm_pkg.sv
rtl/flptm_cmd_if.sv
rtl/flptm_rsp_if.sv
rtl/flptm_alu.sv
rtl/flptm_table_ram.sv
rtl/four_level_page_table_mapper.sv
sim/tb_four_level_page_table_mapper.sv
